// ===== rtl/itoa_pkg.sv =====
`timescale 1ns / 1ps

package itoa_pkg;

   // widest field in characters; wider requests saturate here
   localparam int MAX_WIDTH = 32;
   // bits that hold a field width, a pad count or a character count
   localparam int W_BITS = $clog2(MAX_WIDTH + 1);

   // ten decimal digits hold any 32-bit magnitude, eight hex digits fit the same store
   localparam int NUM_DIGITS = 10;
   localparam int DIG_BITS   = 4 * NUM_DIGITS;
   localparam int IDX_BITS   = $clog2(NUM_DIGITS);

   // binary to decimal conversion takes two bits per cycle
   localparam int ITERS     = 16;
   localparam int ITER_BITS = $clog2(ITERS);

   // conversion kinds
   localparam logic [2:0] CONV_SDEC = 3'd0;
   localparam logic [2:0] CONV_UDEC = 3'd1;
   localparam logic [2:0] CONV_HEXL = 3'd2;
   localparam logic [2:0] CONV_HEXU = 3'd3;
   localparam logic [2:0] CONV_PTR  = 3'd4;

   // where the next character comes from
   typedef enum logic [1:0] {
      SRC_SPACE,
      SRC_SIGN,
      SRC_ZERO,
      SRC_DIGIT
   } src_type;

   // controller to datapath
   typedef struct packed {
      logic    load;
      logic    step;
      logic    measure;
      logic    emit;
      src_type src;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic conv_done;
      logic pad_nz;
      logic pad_one;
      logic idx_zero;
      logic neg;
      logic left;
      logic zero;
   } status_type;

endpackage

// ===== rtl/itoa_ctrl.sv =====
`timescale 1ns / 1ps

module itoa_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic [2:0]           req_conv,
   input  itoa_pkg::status_type status,
   output itoa_pkg::cmd_type    cmd,
   output logic                 busy
);
   import itoa_pkg::*;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_CONVERT,
      ST_MEASURE,
      ST_PLAN,
      ST_LEAD,
      ST_SIGN,
      ST_ZEROS,
      ST_DIGITS,
      ST_TRAIL
   } state_type;

   state_type state_ff;
   state_type state_in;

   logic is_dec;
   logic conv_ok;
   logic want_lead;
   logic want_zeros;
   logic want_trail;

   // decode of the incoming conversion kind
   assign is_dec  = (req_conv == CONV_SDEC) || (req_conv == CONV_UDEC);
   assign conv_ok = (req_conv <= CONV_PTR);

   // which padding phase this field uses
   assign want_lead  = !status.left && !status.zero && status.pad_nz;
   assign want_zeros = !status.left && status.zero && status.pad_nz;
   assign want_trail = status.left && status.pad_nz;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (start && conv_ok) begin
               state_in = is_dec ? ST_CONVERT : ST_MEASURE;
            end
         end
         ST_CONVERT: begin
            if (status.conv_done) begin
               state_in = ST_MEASURE;
            end
         end
         ST_MEASURE: begin
            state_in = ST_PLAN;
         end
         ST_PLAN: begin
            priority if (want_lead) begin
               state_in = ST_LEAD;
            end else if (status.neg) begin
               state_in = ST_SIGN;
            end else if (want_zeros) begin
               state_in = ST_ZEROS;
            end else begin
               state_in = ST_DIGITS;
            end
         end
         ST_LEAD: begin
            if (status.pad_one) begin
               state_in = status.neg ? ST_SIGN : ST_DIGITS;
            end
         end
         ST_SIGN: begin
            state_in = want_zeros ? ST_ZEROS : ST_DIGITS;
         end
         ST_ZEROS: begin
            if (status.pad_one) begin
               state_in = ST_DIGITS;
            end
         end
         ST_DIGITS: begin
            if (status.idx_zero) begin
               state_in = want_trail ? ST_TRAIL : ST_IDLE;
            end
         end
         ST_TRAIL: begin
            if (status.pad_one) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // commands to the datapath
   always_comb begin
      cmd         = '0;
      cmd.src     = SRC_DIGIT;
      cmd.load    = (state_ff == ST_IDLE) && start;
      cmd.step    = (state_ff == ST_CONVERT);
      cmd.measure = (state_ff == ST_MEASURE);
      unique case (state_ff)
         ST_LEAD: begin
            cmd.emit = 1'b1;
            cmd.src  = SRC_SPACE;
         end
         ST_SIGN: begin
            cmd.emit = 1'b1;
            cmd.src  = SRC_SIGN;
         end
         ST_ZEROS: begin
            cmd.emit = 1'b1;
            cmd.src  = SRC_ZERO;
         end
         ST_DIGITS: begin
            cmd.emit = 1'b1;
            cmd.src  = SRC_DIGIT;
         end
         ST_TRAIL: begin
            cmd.emit = 1'b1;
            cmd.src  = SRC_SPACE;
         end
         default: begin
            cmd.emit = 1'b0;
         end
      endcase
   end

   assign busy = (state_ff != ST_IDLE);

endmodule

// ===== rtl/itoa_datapath.sv =====
`timescale 1ns / 1ps

module itoa_datapath (
   input  logic                 clock,
   input  logic                 reset,
   input  itoa_pkg::cmd_type    cmd,
   output itoa_pkg::status_type status,
   input  logic [2:0]           req_conv,
   input  logic [31:0]          req_value,
   input  logic [5:0]           req_width,
   input  logic                 req_zero_fill,
   input  logic                 req_left_align,
   output logic [6:0]           rsp_ch,
   output logic                 rsp_last,
   output logic                 rsp_valid
);
   import itoa_pkg::*;

   localparam logic [6:0] ASCII_SPACE = 7'h20;
   localparam logic [6:0] ASCII_MINUS = 7'h2D;
   localparam logic [6:0] ASCII_ZERO  = 7'h30;
   localparam logic [6:0] ASCII_LA    = 7'h61;
   localparam logic [6:0] ASCII_UA    = 7'h41;

   // one shift-and-adjust step of binary to decimal conversion
   function automatic logic [DIG_BITS-1:0] dabble(input logic [DIG_BITS-1:0] bcd,
                                                  input logic               bit_in);
      logic [DIG_BITS-1:0] adj;
      adj = bcd;
      for (int i = 0; i < NUM_DIGITS; i++) begin
         if (bcd[i*4 +: 4] >= 4'd5) begin
            adj[i*4 +: 4] = bcd[i*4 +: 4] + 4'd3;
         end
      end
      return {adj[DIG_BITS-2:0], bit_in};
   endfunction

   // position of the most significant nonzero digit, zero for a zero value
   function automatic logic [IDX_BITS-1:0] top_digit(input logic [DIG_BITS-1:0] d);
      logic [IDX_BITS-1:0] t;
      t = '0;
      for (int i = 1; i < NUM_DIGITS; i++) begin
         if (d[i*4 +: 4] != 4'd0) begin
            t = IDX_BITS'(i);
         end
      end
      return t;
   endfunction

   // ascii of one digit value
   function automatic logic [6:0] digit_char(input logic [3:0] d, input logic up);
      logic [6:0] c;
      if (d < 4'd10) begin
         c = ASCII_ZERO + {3'b000, d};
      end else if (up) begin
         c = ASCII_UA + {3'b000, d - 4'd10};
      end else begin
         c = ASCII_LA + {3'b000, d - 4'd10};
      end
      return c;
   endfunction

   logic [DIG_BITS-1:0]  digits_ff;
   logic [31:0]          bin_ff;
   logic [ITER_BITS-1:0] iter_ff;
   logic [W_BITS-1:0]    width_ff;
   logic [W_BITS-1:0]    pad_ff;
   logic [W_BITS-1:0]    remain_ff;
   logic [IDX_BITS-1:0]  idx_ff;
   logic                 neg_ff;
   logic                 upper_ff;
   logic                 zero_ff;
   logic                 left_ff;
   logic [6:0]           ch_ff;
   logic                 last_ff;
   logic                 valid_ff;

   logic                 ld_neg;
   logic                 ld_hex;
   logic                 ld_ptr;
   logic [31:0]          ld_mag;
   logic [W_BITS-1:0]    ld_width;
   logic [DIG_BITS-1:0]  step_digits;
   logic [IDX_BITS-1:0]  top_idx;
   logic [W_BITS-1:0]    need;
   logic [6:0]           ch_in;

   // decode of a new request
   always_comb begin
      ld_neg = (req_conv == CONV_SDEC) && req_value[31];
      ld_mag = ld_neg ? (32'd0 - req_value) : req_value;
      ld_ptr = (req_conv == CONV_PTR);
      ld_hex = (req_conv == CONV_HEXL) || (req_conv == CONV_HEXU) || ld_ptr;
      if (ld_ptr) begin
         ld_width = W_BITS'(8);
      end else if (int'(req_width) > MAX_WIDTH) begin
         ld_width = W_BITS'(MAX_WIDTH);
      end else begin
         ld_width = W_BITS'(req_width);
      end
   end

   // two conversion steps per cycle
   assign step_digits = dabble(dabble(digits_ff, bin_ff[31]), bin_ff[30]);

   // digit count and padding
   assign top_idx = top_digit(digits_ff);
   assign need    = W_BITS'(top_idx) + W_BITS'(1) + W_BITS'(neg_ff);

   // digit store, conversion and field bookkeeping
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         neg_ff   <= ld_neg;
         upper_ff <= (req_conv == CONV_HEXU);
         zero_ff  <= req_zero_fill || ld_ptr;
         left_ff  <= req_left_align && !ld_ptr;
         width_ff <= ld_width;
         iter_ff  <= '0;
         bin_ff   <= ld_mag;
         if (ld_hex) begin
            digits_ff <= {{(DIG_BITS - 32){1'b0}}, req_value};
         end else begin
            digits_ff <= '0;
         end
      end else if (cmd.step) begin
         digits_ff <= step_digits;
         bin_ff    <= {bin_ff[29:0], 2'b00};
         iter_ff   <= iter_ff + ITER_BITS'(1);
      end else if (cmd.measure) begin
         idx_ff <= top_idx;
         if (width_ff > need) begin
            pad_ff    <= width_ff - need;
            remain_ff <= width_ff;
         end else begin
            pad_ff    <= '0;
            remain_ff <= need;
         end
      end else if (cmd.emit) begin
         remain_ff <= remain_ff - W_BITS'(1);
         unique case (cmd.src)
            SRC_DIGIT: idx_ff <= idx_ff - IDX_BITS'(1);
            SRC_SIGN:  idx_ff <= idx_ff;
            SRC_SPACE: pad_ff <= pad_ff - W_BITS'(1);
            SRC_ZERO:  pad_ff <= pad_ff - W_BITS'(1);
            default:   idx_ff <= idx_ff;
         endcase
      end
   end

   // character select
   always_comb begin
      unique case (cmd.src)
         SRC_SPACE: ch_in = ASCII_SPACE;
         SRC_SIGN:  ch_in = ASCII_MINUS;
         SRC_ZERO:  ch_in = ASCII_ZERO;
         SRC_DIGIT: ch_in = digit_char(digits_ff[{idx_ff, 2'b00} +: 4], upper_ff);
         default:   ch_in = ASCII_SPACE;
      endcase
   end

   // output register, one character per transfer
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= cmd.emit;
      end
      ch_ff   <= ch_in;
      last_ff <= (remain_ff == W_BITS'(1));
   end

   assign rsp_ch    = ch_ff;
   assign rsp_last  = last_ff;
   assign rsp_valid = valid_ff;

   // status to the controller
   always_comb begin
      status.conv_done = (iter_ff == ITER_BITS'(ITERS - 1));
      status.pad_nz    = (pad_ff != '0);
      status.pad_one   = (pad_ff == W_BITS'(1));
      status.idx_zero  = (idx_ff == '0);
      status.neg       = neg_ff;
      status.left      = left_ff;
      status.zero      = zero_ff;
   end

endmodule

// ===== rtl/integer_to_ascii_padded.sv =====
`timescale 1ns / 1ps
// start of a field: decimal kinds run the binary to decimal converter and then the measure
//   and plan states before the first character, hex and pointer kinds only the latter two
// a new request is taken only when the block is idle again, after the final character of
//   a field, sent one per cycle; unused kinds are taken with no work and no result
// reset: synchronous, active high; clears the controller and the result strobe
// the receiver cannot stall: each character is valid for exactly one cycle

module integer_to_ascii_padded (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [2:0]  req_conv,
   input  logic [31:0] req_value,
   input  logic [5:0]  req_width,
   input  logic        req_zero_fill,
   input  logic        req_left_align,
   output logic [6:0]  rsp_ch,
   output logic        rsp_last,
   output logic        rsp_valid
);
   import itoa_pkg::*;

   cmd_type    cmd;
   status_type status;

   // sequencing of conversion and character phases
   itoa_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .req_conv (req_conv),
      .status   (status),
      .cmd      (cmd),
      .busy     (busy)
   );

   // digit store, counters and output register
   itoa_datapath u_datapath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .status         (status),
      .req_conv       (req_conv),
      .req_value      (req_value),
      .req_width      (req_width),
      .req_zero_fill  (req_zero_fill),
      .req_left_align (req_left_align),
      .rsp_ch         (rsp_ch),
      .rsp_last       (rsp_last),
      .rsp_valid      (rsp_valid)
   );

endmodule

// ===== rtl/itoa_checker.sv =====
`timescale 1ns / 1ps

module itoa_checker (
   input logic       clock,
   input logic       reset,
   input logic       start,
   input logic       busy,
   input logic [2:0] req_conv,
   input logic       rsp_valid,
   input logic       rsp_last
);
   import itoa_pkg::*;

   // after reset nothing is in flight
   a_reset_idle: assert property (@(posedge clock)
      reset |=> !busy && !rsp_valid)
      else $error("busy or result strobe after reset");

   // a valid kind starts work
   a_start_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy && (req_conv <= CONV_PTR) |=> busy)
      else $error("accepted transfer did not start work");

   // an unused kind does no work
   a_bad_conv_idle: assert property (@(posedge clock) disable iff (reset)
      start && !busy && (req_conv > CONV_PTR) |=> !busy && !rsp_valid)
      else $error("unused kind started work");

   // characters of one field come in consecutive cycles
   a_field_contig: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_last |=> rsp_valid)
      else $error("gap inside a field");

   // the block stays busy until the final character of a field
   a_busy_until_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_last |-> busy)
      else $error("idle before the final character");

endmodule

bind integer_to_ascii_padded itoa_checker u_itoa_checker (
   .clock     (clock),
   .reset     (reset),
   .start     (start),
   .busy      (busy),
   .req_conv  (req_conv),
   .rsp_valid (rsp_valid),
   .rsp_last  (rsp_last)
);
